>>> rtl/ukst_pkg.sv
`default_nettype none
package ukst_pkg;

    localparam int CAPACITY = 128;
    localparam int KEY_W    = 32;
    localparam int POS_W    = 7;
    localparam int STAT_W   = 3;
    localparam int ECNT_W   = 8;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;

    typedef logic [CMP_W-1:0] t_cmp;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [KEY_W-1:0] t_key;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_FIND   = 2'd2,
        FN_READ   = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 3'd0,
        ST_DUP     = 3'd1,
        ST_FULL    = 3'd2,
        ST_MISSING = 3'd3,
        ST_BADPOS  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_CMP  = 2'd1,
        S_RED  = 2'd2,
        S_UPD  = 2'd3
    } t_state;

    typedef struct packed {
        logic [1:0]        func;
        logic signed [31:0] key_value;
        logic [POS_W-1:0]  position;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  found_position;
        logic signed [31:0] read_value;
        logic [ECNT_W-1:0] entry_count;
    } t_rsp;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> rtl/ukst_req_if.sv
`default_nettype none
interface ukst_req_if import ukst_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/ukst_rsp_if.sv
`default_nettype none
interface ukst_rsp_if import ukst_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/ukst_cell.sv
`default_nettype none
module ukst_cell import ukst_pkg::*; (
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire t_cmp      i_index,
    input  wire t_cmp      i_count,
    input  wire t_cmp      i_pos,
    input  wire t_cmp      i_hit_pos,
    input  wire t_key      i_key,
    input  wire t_key      i_next_key,
    output t_key           o_key,
    output logic           o_match,
    output t_key           o_sel_key
);

    t_key r_key;
    logic r_match;
    logic r_sel;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_match <= (i_index < i_count) && (r_key == i_key);
            r_sel   <= (i_index < i_count) && (i_index == i_pos);
        end
        if (i_ctl.ins && (i_index == i_count)) begin
            r_key <= i_key;
        end else if (i_ctl.del && (i_index >= i_hit_pos)) begin
            r_key <= i_next_key;
        end
    end

    assign o_key     = r_key;
    assign o_match   = r_match;
    assign o_sel_key = r_sel ? r_key : '0;

endmodule
`default_nettype wire

>>> rtl/ukst_reduce.sv
`default_nettype none
module ukst_reduce import ukst_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [CAPACITY-1:0] i_match,
    input  wire t_key                i_sel_key [CAPACITY],
    output logic                     o_hit,
    output t_cmp                     o_hit_pos,
    output t_key                     o_data
);

    logic             w_hit;
    logic [IDX_W-1:0] w_pos;
    t_key             w_data;
    logic             r_hit;
    t_cmp             r_hit_pos;
    t_key             r_data;

    // keys are distinct, so at most one cell matches: OR-encode its index
    always_comb begin
        w_hit  = |i_match;
        w_pos  = '0;
        w_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            for (int b = 0; b < IDX_W; b++) begin
                if (((i >> b) & 1) == 1) begin
                    w_pos[b] = w_pos[b] | i_match[i];
                end
            end
            w_data = w_data | i_sel_key[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit     <= w_hit;
            r_hit_pos <= w_hit ? t_cmp'(w_pos) : t_cmp'(CAPACITY);
            r_data    <= w_data;
        end
    end

    assign o_hit     = r_hit;
    assign o_hit_pos = r_hit_pos;
    assign o_data    = r_data;

endmodule
`default_nettype wire

>>> rtl/unique_key_set_table.sv
// Sequence: an accepted request passes through the compare, reduce and update states, in
// that order, before the response is registered; the cell row handles one request at a
// time, and a held response stalls the update step.
// Reset: synchronous active-low i_rst_n clears the entry count, sequencer and response
// valid; stored keys are not cleared and are only visible below the entry count.
`default_nettype none
module unique_key_set_table import ukst_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ukst_req_if.sink    i_req,
    ukst_rsp_if.source  o_rsp
);

    t_state    r_state;
    t_state    n_state;
    t_req      r_req;
    t_cnt      r_count;
    t_cnt      n_count;
    t_rsp      r_rsp;
    t_rsp      n_rsp;
    logic      r_rsp_valid;
    logic      w_load;
    t_cell_ctl w_ctl;

    logic [CAPACITY-1:0] w_match;
    t_key                w_key     [CAPACITY];
    t_key                w_sel_key [CAPACITY];
    logic                w_hit;
    t_cmp                w_hit_pos;
    t_key                w_data;
    t_cmp                w_count;
    t_cmp                w_pos;
    logic                w_full;

    assign w_count = t_cmp'(r_count);
    assign w_pos   = t_cmp'(r_req.position);
    assign w_full  = (r_count == t_cnt'(CAPACITY));

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ukst_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_index    (t_cmp'(g)),
            .i_count    (w_count),
            .i_pos      (w_pos),
            .i_hit_pos  (w_hit_pos),
            .i_key      (r_req.key_value),
            .i_next_key (w_key[(g + 1 < CAPACITY) ? g + 1 : g]),
            .o_key      (w_key[g]),
            .o_match    (w_match[g]),
            .o_sel_key  (w_sel_key[g])
        );
    end

    ukst_reduce u_reduce (
        .i_clk     (i_clk),
        .i_en      (r_state == S_RED),
        .i_match   (w_match),
        .i_sel_key (w_sel_key),
        .o_hit     (w_hit),
        .o_hit_pos (w_hit_pos),
        .o_data    (w_data)
    );

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        w_ctl         = '0;
        w_load        = 1'b0;
        n_rsp         = '0;
        n_rsp.status  = ST_DONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                w_ctl.cmp = 1'b1;
                n_state   = S_RED;
            end
            S_RED: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                    unique case (t_func'(r_req.func))
                        FN_INSERT: begin
                            if (w_hit) begin
                                n_rsp.status = ST_DUP;
                            end else if (w_full) begin
                                n_rsp.status = ST_FULL;
                            end else begin
                                w_ctl.ins = 1'b1;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        FN_DELETE: begin
                            if (w_hit) begin
                                w_ctl.del = 1'b1;
                                n_count   = r_count - 1'b1;
                            end else begin
                                n_rsp.status = ST_MISSING;
                            end
                        end
                        FN_FIND: begin
                            if (w_hit) begin
                                n_rsp.found_position = POS_W'(w_hit_pos);
                            end else begin
                                n_rsp.status = ST_MISSING;
                            end
                        end
                        FN_READ: begin
                            if (w_pos >= w_count) begin
                                n_rsp.status = ST_BADPOS;
                            end else begin
                                n_rsp.read_value = w_data;
                            end
                        end
                        default: begin
                            n_rsp.status = ST_DONE;
                        end
                    endcase
                    n_rsp.entry_count = ECNT_W'(n_count);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.data;
        end
        if (w_load) begin
            r_rsp <= n_rsp;
        end
    end

    assign i_req.ready = (r_state == S_IDLE) && i_rst_n;
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

endmodule
`default_nettype wire

>>> tb/tb_unique_key_set_table.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_unique_key_set_table;
    import ukst_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 500_000;
    localparam int unsigned POOL_SIZE    = 160;
    localparam int unsigned HOLD_CYCLES  = 300;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ukst_req_if req_if ();
    ukst_rsp_if rsp_if ();

    unique_key_set_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #6 i_clk = ~i_clk;

    // predicted table contents
    logic [31:0] table_keys [CAPACITY];
    int unsigned table_fill;
    logic [31:0] key_pool [POOL_SIZE];

    t_rsp        pending_rsps [$];
    int unsigned mismatch_count;
    bit          fast_mode;
    int unsigned hold_token;

    function automatic int locate_key(input logic [31:0] key);
        for (int unsigned i = 0; i < table_fill; i++) begin
            if (table_keys[i] == key) return int'(i);
        end
        return -1;
    endfunction

    function automatic t_rsp table_apply(input t_req r);
        t_rsp rsp;
        int   hit;
        rsp                = '0;
        rsp.status         = ST_DONE;
        hit                = locate_key(r.key_value);
        case (r.func)
            FN_INSERT: begin
                if (hit >= 0) begin
                    rsp.status = ST_DUP;
                end else if (table_fill >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    table_keys[table_fill] = r.key_value;
                    table_fill++;
                end
            end
            FN_DELETE: begin
                if (hit < 0) begin
                    rsp.status = ST_MISSING;
                end else begin
                    for (int unsigned i = hit; i + 1 < table_fill; i++) begin
                        table_keys[i] = table_keys[i+1];
                    end
                    table_fill--;
                end
            end
            FN_FIND: begin
                if (hit < 0) rsp.status = ST_MISSING;
                else rsp.found_position = hit[POS_W-1:0];
            end
            default: begin
                if (r.position >= table_fill) rsp.status = ST_BADPOS;
                else rsp.read_value = table_keys[r.position];
            end
        endcase
        rsp.entry_count = table_fill[ECNT_W-1:0];
        return rsp;
    endfunction

    function automatic int unsigned draw_wait();
        if (fast_mode) return 0;
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 17);
        return $urandom_range(0, 2);
    endfunction

    function automatic logic [31:0] pick_key(input bit prefer_stored);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (prefer_stored && table_fill != 0 && r < 60)
            return table_keys[$urandom_range(0, table_fill - 1)];
        if (r < 80) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic send_request(input t_func fn, input logic [31:0] key,
                                input logic [POS_W-1:0] pos);
        int unsigned gap;
        t_req        r;
        gap = draw_wait();
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        r.func      = fn;
        r.key_value = key;
        r.position  = pos;
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        pending_rsps.push_back(table_apply(r));
    endtask

    task automatic send_random(input int unsigned ins_w, input int unsigned del_w,
                               input int unsigned find_w);
        int unsigned      r;
        logic [POS_W-1:0] pos;
        r   = $urandom_range(0, 99);
        pos = POS_W'($urandom_range(0, 127));
        if (r < ins_w) begin
            send_request(FN_INSERT, pick_key(1'b0), pos);
        end else if (r < ins_w + del_w) begin
            send_request(FN_DELETE, pick_key(1'b1), pos);
        end else if (r < ins_w + del_w + find_w) begin
            send_request(FN_FIND, pick_key(1'b1), pos);
        end else begin
            if (table_fill != 0 && $urandom_range(0, 9) < 7)
                pos = POS_W'($urandom_range(0, table_fill - 1));
            send_request(FN_READ, $urandom, pos);
        end
    endtask

    task automatic wait_all_responses();
        int unsigned guard;
        guard = 0;
        req_if.valid <= 1'b0;
        while (pending_rsps.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_rsps.size() != 0)
            report_mismatch("responses still pending", pending_rsps.size(), 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic test_directed_ops();
        send_request(FN_READ,   32'h0000_0000, 7'd0);
        send_request(FN_FIND,   32'h0000_0005, 7'd0);
        send_request(FN_DELETE, 32'h0000_0005, 7'd0);
        send_request(FN_INSERT, 32'h8000_0000, 7'd0);
        send_request(FN_INSERT, 32'h7FFF_FFFF, 7'd127);
        send_request(FN_INSERT, 32'h0000_0000, 7'd0);
        send_request(FN_INSERT, 32'hFFFF_FFFF, 7'd127);
        send_request(FN_INSERT, 32'h7FFF_FFFF, 7'd0);
        send_request(FN_FIND,   32'h8000_0000, 7'd0);
        send_request(FN_FIND,   32'hFFFF_FFFF, 7'd0);
        send_request(FN_FIND,   32'h1234_5678, 7'd0);
        send_request(FN_READ,   32'hFFFF_FFFF, 7'd0);
        send_request(FN_READ,   32'h0000_0000, 7'd3);
        send_request(FN_READ,   32'h0000_0000, 7'd4);
        send_request(FN_READ,   32'h0000_0000, 7'd127);
        send_request(FN_DELETE, 32'h0000_0000, 7'd0);
        send_request(FN_READ,   32'h0000_0000, 7'd2);
        send_request(FN_DELETE, 32'h0000_0000, 7'd0);
        send_request(FN_DELETE, 32'h8000_0000, 7'd0);
        send_request(FN_FIND,   32'hFFFF_FFFF, 7'd0);
        send_request(FN_DELETE, 32'hFFFF_FFFF, 7'd0);
        send_request(FN_READ,   32'h0000_0000, 7'd0);
        send_request(FN_DELETE, 32'h7FFF_FFFF, 7'd0);
        send_request(FN_INSERT, 32'h5555_5555, 7'd0);
        wait_all_responses();
    endtask

    task automatic test_rsp_holdoff();
        hold_token++;
        for (int i = 0; i < 40; i++) send_random(60, 15, 15);
        wait_all_responses();
    endtask

    task automatic test_back_to_back();
        fast_mode = 1'b1;
        for (int i = 0; i < 60; i++) send_random(40, 20, 20);
        fast_mode = 1'b0;
        wait_all_responses();
    endtask

    task automatic test_random_mix();
        for (int blk = 0; blk < 7; blk++) begin
            fast_mode = (blk == 3);
            for (int i = 0; i < 250; i++) begin
                if (blk % 2 == 0) send_random(75, 10, 8);
                else send_random(10, 65, 12);
            end
            fast_mode = 1'b0;
            if (blk == 4) wait_all_responses();
        end
        wait_all_responses();
    endtask

    // response sink: per-result stall plus a long hold-off on request
    initial begin : rsp_sink
        int unsigned wait_left;
        int unsigned hold_left;
        int unsigned hold_seen;
        bit          taken;
        rsp_if.ready <= 1'b0;
        wait_left = 0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            taken = (rsp_if.valid === 1'b1) && (rsp_if.ready === 1'b1);
            if (taken) wait_left = draw_wait();
            else if (rsp_if.valid === 1'b1 && wait_left != 0) wait_left--;
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= (wait_left == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_rsps.size() == 0) begin
                report_mismatch("response with none pending", rsp_if.data.read_value, 0);
            end else begin
                want = pending_rsps.pop_front();
                if (rsp_if.data.status !== want.status)
                    report_mismatch("status", 32'(rsp_if.data.status), 32'(want.status));
                if (rsp_if.data.found_position !== want.found_position)
                    report_mismatch("found_position", 32'(rsp_if.data.found_position),
                                    32'(want.found_position));
                if (rsp_if.data.read_value !== want.read_value)
                    report_mismatch("read_value", rsp_if.data.read_value, want.read_value);
                if (rsp_if.data.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 32'(rsp_if.data.entry_count),
                                    32'(want.entry_count));
            end
        end
    end

    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        table_fill     = 0;
        mismatch_count = 0;
        fast_mode      = 1'b0;
        hold_token     = 0;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        key_pool[4] = 32'h0000_0001;
        for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = $urandom;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_ops();
        test_rsp_holdoff();
        test_back_to_back();
        test_random_mix();

        wait_all_responses();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0 && pending_rsps.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> unique_key_set_table.f
rtl/ukst_pkg.sv
rtl/ukst_req_if.sv
rtl/ukst_rsp_if.sv
rtl/ukst_cell.sv
rtl/ukst_reduce.sv
rtl/unique_key_set_table.sv
tb/tb_unique_key_set_table.sv
